>>> rtl/core/svmm_pkg.sv
// shared types and constants for the svpwm min-max duty core
// no dependencies; imported by every module of the core
package svmm_pkg;

   localparam int VOLT_WIDTH = 16;
   localparam int DUTY_WIDTH = 16;

   // quotient carries one extra bit to spot duties of one or more
   localparam int QUO_WIDTH   = DUTY_WIDTH + 1;
   // signed numerator bus + 2*v - (max + min)
   localparam int NUM_WIDTH   = VOLT_WIDTH + 2;
   // divider: one setup stage plus one stage per quotient bit
   localparam int DIV_LATENCY = QUO_WIDTH + 1;

   typedef logic signed [VOLT_WIDTH-1:0] volt_type;
   typedef logic [VOLT_WIDTH-1:0]        bus_type;
   typedef logic [DUTY_WIDTH-1:0]        duty_type;
   typedef logic signed [NUM_WIDTH-1:0]  num_type;

   typedef enum logic {
      STATUS_OK      = 1'b0,
      STATUS_BAD_BUS = 1'b1
   } status_type;

   localparam duty_type DUTY_MAX = '1;

   typedef struct packed {
      volt_type phase_u_volt;
      volt_type phase_v_volt;
      volt_type phase_w_volt;
      bus_type  bus_volt;
   } req_type;

   typedef struct packed {
      duty_type   duty_u_frac;
      duty_type   duty_v_frac;
      duty_type   duty_w_frac;
      status_type status;
   } rsp_type;

endpackage

>>> rtl/core/svmm_duty_div.sv
// pipelined restoring divider for one phase: duty = round(n * 2^DUTY_WIDTH / (2 * bus))
// with clamping to 0 and DUTY_MAX; depends on svmm_pkg
module svmm_duty_div import svmm_pkg::*; (
   input  logic     clock,
   input  num_type  num_in,
   input  bus_type  bus_in,
   output duty_type duty_out
);

   localparam int REM_WIDTH = VOLT_WIDTH + 1;
   localparam int DVD_WIDTH = VOLT_WIDTH + DUTY_WIDTH + 2;

   logic [REM_WIDTH-1:0] twice_bus;
   logic [DVD_WIDTH-1:0] dividend;
   logic                 clip_low;
   logic                 clip_high;

   logic [REM_WIDTH-1:0] rem_ff  [0:QUO_WIDTH];
   logic [QUO_WIDTH-1:0] quo_ff  [0:QUO_WIDTH];
   logic                 zero_ff [0:QUO_WIDTH];
   logic                 sat_ff  [0:QUO_WIDTH];
   logic [QUO_WIDTH-1:0] low_ff  [0:QUO_WIDTH-1];
   logic [REM_WIDTH-1:0] dsr_ff  [0:QUO_WIDTH-1];

   // setup: clamp flags and the rounded dividend n * 2^DUTY_WIDTH + bus
   always_comb begin
      twice_bus = {bus_in, 1'b0};
      dividend  = {1'b0, num_in[VOLT_WIDTH:0], {DUTY_WIDTH{1'b0}}} + DVD_WIDTH'(bus_in);
      clip_low  = num_in[NUM_WIDTH-1] | (num_in == '0);
      clip_high = (num_in >= $signed({1'b0, twice_bus}));
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= dividend[DVD_WIDTH-1 -: REM_WIDTH];
      low_ff[0]  <= dividend[QUO_WIDTH-1:0];
      quo_ff[0]  <= '0;
      dsr_ff[0]  <= twice_bus;
      zero_ff[0] <= clip_low;
      sat_ff[0]  <= clip_high;
   end

   for (genvar j = 0; j < QUO_WIDTH; j++) begin : g_step
      logic [REM_WIDTH:0] trial;
      logic [REM_WIDTH:0] diff;
      logic               fits;

      always_comb begin
         trial = {rem_ff[j], low_ff[j][QUO_WIDTH-1-j]};
         diff  = trial - {1'b0, dsr_ff[j]};
         fits  = (trial >= {1'b0, dsr_ff[j]});
      end

      always_ff @(posedge clock) begin
         rem_ff[j+1]  <= fits ? diff[REM_WIDTH-1:0] : trial[REM_WIDTH-1:0];
         quo_ff[j+1]  <= {quo_ff[j][QUO_WIDTH-2:0], fits};
         zero_ff[j+1] <= zero_ff[j];
         sat_ff[j+1]  <= sat_ff[j];
      end

      if (j < QUO_WIDTH - 1) begin : g_carry
         always_ff @(posedge clock) begin
            low_ff[j+1] <= low_ff[j];
            dsr_ff[j+1] <= dsr_ff[j];
         end
      end
   end

   always_comb begin
      priority if (zero_ff[QUO_WIDTH]) begin
         duty_out = '0;
      end else if (sat_ff[QUO_WIDTH] || quo_ff[QUO_WIDTH][QUO_WIDTH-1]) begin
         duty_out = DUTY_MAX;
      end else begin
         duty_out = quo_ff[QUO_WIDTH][DUTY_WIDTH-1:0];
      end
   end

endmodule

>>> rtl/core/svpwm_minmax_duty_core.sv
// top level of the svpwm min-max zero-sequence duty core
// depends on svmm_pkg and svmm_duty_div (three instances, one per phase)
//
//  channel   ports                        direction  transfer when
//  --------  ---------------------------  ---------  ---------------------------
//  request   start, busy, req_data        in         start high and busy low
//  response  rsp_strobe, rsp_data         out        rsp_strobe high (one cycle)
//
// one request transfer per clock; busy never rises, the pipeline has no stall
// rsp_strobe rises once a request has passed the four front stages, the restoring
// divider with one quotient bit per stage, and the output register
// results leave in request order, one per request
// reset is synchronous and clears only the valid bits; payload flows unreset
// the receiver cannot hold results off, so nothing here ever waits
module svpwm_minmax_duty_core import svmm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int PIPE_LATENCY = DIV_LATENCY + 5;

   // stage 1: input register
   req_type s1_req_ff;
   logic    s1_vld_ff;

   // stage 2: largest and smallest phase command
   volt_type s2_u_ff, s2_v_ff, s2_w_ff;
   volt_type s2_hi_ff, s2_lo_ff;
   bus_type  s2_bus_ff;
   logic     s2_vld_ff;
   volt_type hi_in, lo_in;

   // stage 3: common-mode sum max + min
   volt_type                s3_u_ff, s3_v_ff, s3_w_ff;
   logic signed [VOLT_WIDTH:0] s3_sum_ff;
   bus_type                 s3_bus_ff;
   logic                    s3_vld_ff;

   // stage 4: per-phase numerator bus + 2*v - sum
   num_type s4_nu_ff, s4_nv_ff, s4_nw_ff;
   num_type nu_in, nv_in, nw_in;
   bus_type s4_bus_ff;
   logic    s4_bz_ff;
   logic    s4_vld_ff;

   // valid and zero-bus flag run beside the dividers
   logic dv_vld_ff [0:DIV_LATENCY-1];
   logic dv_bz_ff  [0:DIV_LATENCY-1];

   duty_type duty_u, duty_v, duty_w;

   rsp_type rsp_ff;
   logic    rsp_vld_ff;

   function automatic num_type center_num(volt_type x, logic signed [VOLT_WIDTH:0] sum,
                                          bus_type bus);
      num_type x2;
      num_type s;
      num_type b;
      x2 = {x[VOLT_WIDTH-1], x, 1'b0};
      s  = {sum[VOLT_WIDTH], sum};
      b  = {2'b00, bus};
      return b + x2 - s;
   endfunction

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
      s1_req_ff <= req_data;
   end

   always_comb begin
      hi_in = s1_req_ff.phase_u_volt;
      if (s1_req_ff.phase_v_volt > hi_in) hi_in = s1_req_ff.phase_v_volt;
      if (s1_req_ff.phase_w_volt > hi_in) hi_in = s1_req_ff.phase_w_volt;
      lo_in = s1_req_ff.phase_u_volt;
      if (s1_req_ff.phase_v_volt < lo_in) lo_in = s1_req_ff.phase_v_volt;
      if (s1_req_ff.phase_w_volt < lo_in) lo_in = s1_req_ff.phase_w_volt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_u_ff   <= s1_req_ff.phase_u_volt;
      s2_v_ff   <= s1_req_ff.phase_v_volt;
      s2_w_ff   <= s1_req_ff.phase_w_volt;
      s2_bus_ff <= s1_req_ff.bus_volt;
      s2_hi_ff  <= hi_in;
      s2_lo_ff  <= lo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_u_ff   <= s2_u_ff;
      s3_v_ff   <= s2_v_ff;
      s3_w_ff   <= s2_w_ff;
      s3_bus_ff <= s2_bus_ff;
      // sign-extended sum, exact in one extra bit
      s3_sum_ff <= {s2_hi_ff[VOLT_WIDTH-1], s2_hi_ff} + {s2_lo_ff[VOLT_WIDTH-1], s2_lo_ff};
   end

   always_comb begin
      nu_in = center_num(s3_u_ff, s3_sum_ff, s3_bus_ff);
      nv_in = center_num(s3_v_ff, s3_sum_ff, s3_bus_ff);
      nw_in = center_num(s3_w_ff, s3_sum_ff, s3_bus_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_nu_ff  <= nu_in;
      s4_nv_ff  <= nv_in;
      s4_nw_ff  <= nw_in;
      s4_bus_ff <= s3_bus_ff;
      s4_bz_ff  <= (s3_bus_ff == '0);
   end

   // one divider per phase, all sharing the divisor 2*bus
   svmm_duty_div u_div_u (
      .clock    (clock),
      .num_in   (s4_nu_ff),
      .bus_in   (s4_bus_ff),
      .duty_out (duty_u)
   );

   svmm_duty_div u_div_v (
      .clock    (clock),
      .num_in   (s4_nv_ff),
      .bus_in   (s4_bus_ff),
      .duty_out (duty_v)
   );

   svmm_duty_div u_div_w (
      .clock    (clock),
      .num_in   (s4_nw_ff),
      .bus_in   (s4_bus_ff),
      .duty_out (duty_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= s4_vld_ff;
      end
      dv_bz_ff[0] <= s4_bz_ff;
   end

   for (genvar k = 1; k < DIV_LATENCY; k++) begin : g_align
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
         dv_bz_ff[k] <= dv_bz_ff[k-1];
      end
   end

   // output register; zero bus forces zero duties and the invalid status
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= dv_vld_ff[DIV_LATENCY-1];
      end
      if (dv_bz_ff[DIV_LATENCY-1]) begin
         rsp_ff.duty_u_frac <= '0;
         rsp_ff.duty_v_frac <= '0;
         rsp_ff.duty_w_frac <= '0;
         rsp_ff.status      <= STATUS_BAD_BUS;
      end else begin
         rsp_ff.duty_u_frac <= duty_u;
         rsp_ff.duty_v_frac <= duty_v;
         rsp_ff.duty_w_frac <= duty_w;
         rsp_ff.status      <= STATUS_OK;
      end
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   // every response traces back to an earlier request transfer
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, PIPE_LATENCY))
      else $error("response without a matching request transfer");

   // invalid status only for a zero bus, and then all duties are zero
   a_bad_bus: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_BAD_BUS) |->
         ($past(req_data.bus_volt, PIPE_LATENCY) == '0 && rsp_data.duty_u_frac == '0 &&
          rsp_data.duty_v_frac == '0 && rsp_data.duty_w_frac == '0))
      else $error("invalid status without zero bus or with nonzero duty");

   // ok status only for a nonzero bus
   a_good_bus: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_OK) |->
         ($past(req_data.bus_volt, PIPE_LATENCY) != '0))
      else $error("ok status for a zero bus voltage");

endmodule
